FILE: design/tclc_pkg.sv
// Shared types and constants of the two-channel lamp controller.
package tclc_pkg;

	// Controller sequencing
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_WB,
		ST_DONE
	} state_t;

	// Multiply/divide passes that one word may need
	typedef enum logic [2:0] {
		OP_LUX,
		OP_MAN_WARM,
		OP_MAN_COLD,
		OP_SEMI_COLD,
		OP_SEMI_WARM
	} op_t;

	localparam int MODE_BITS     = 2;
	localparam int TARGET_BITS   = 10;
	localparam int CFG_ADDR_BITS = 1;
	localparam int CFG_DATA_BITS = TARGET_BITS;

	localparam logic [MODE_BITS-1:0] MODE_MANUAL = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_SEMI   = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_AUTO   = 2'd2;

	localparam logic [CFG_ADDR_BITS-1:0] REG_MODE   = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET = 1'b1;

	localparam logic [TARGET_BITS-1:0] TARGET_RESET = 10'd100;

	// Full-scale illuminance of the sensor divider
	localparam int LUX_BITS = 8;
	localparam logic [LUX_BITS-1:0] LUX_FULL = 8'd165;

	localparam int INTEG_RESET = 2048;

endpackage

FILE: design/two_channel_lamp_lux_controller.sv
// Top level of the two-channel warm/cold lamp controller.
//
// Each input word carries one sample of the colour knob, brightness knob, light sensor and
// motion sensor; each output word gives the warm and cold drive levels and the lamp-on flag
// after that sample. One word is processed at a time with a shift-add multiplier that takes
// one multiplier bit per cycle and a restoring divider by the converter full scale (or its
// square) that yields one quotient bit per cycle. Manual mode with the lamp on takes two
// passes; semi mode takes one lux pass plus two split passes; auto mode takes the lux pass
// only; manual with the lamp off and the spare mode code skip the passes and go straight
// to the output. The input is ready whenever no word is in work, even while the last
// result still waits in the output register.
module two_channel_lamp_lux_controller #(
	parameter int ADC_BITS   = 12,
	parameter int DRIVE_BITS = 13
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// cfg
	input  logic                                 cfg_we,
	input  logic [tclc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [tclc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	// input word
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// colour_knob, brightness_knob, light_level, motion, zero pad
	input  logic [((3*ADC_BITS+1+7)/8)*8-1:0]    s_tdata,
	// output word
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// warm_drive, cold_drive, lamp_on, zero pad
	output logic [((2*DRIVE_BITS+1+7)/8)*8-1:0]  m_tdata
);

	localparam int AW  = ADC_BITS;
	localparam int DW  = DRIVE_BITS;
	localparam int TW  = tclc_pkg::TARGET_BITS;
	localparam int LB  = tclc_pkg::LUX_BITS;
	localparam int MW  = (AW > DW) ? AW : DW;
	localparam int PW  = MW + AW;
	localparam int XW  = PW + DW;
	localparam int RW  = 2 * AW + 1;
	localparam int QW  = (DW > LB) ? DW : LB;
	localparam int SW  = ((DW > TW) ? DW : TW) + 2;
	localparam int CW  = $clog2(((MW > LB) ? MW : LB) + 1);
	localparam int OBW = ((2 * DW + 1 + 7) / 8) * 8;

	localparam logic [AW-1:0]   ADC_MAX   = '1;
	localparam logic [DW-1:0]   DRIVE_MAX = '1;
	localparam logic [2*AW-1:0] ADC_SQ    = {{AW{1'b0}}, ADC_MAX} * {{AW{1'b0}}, ADC_MAX};
	localparam logic [RW-1:0]   DIV_M     = RW'(ADC_MAX);
	localparam logic [RW-1:0]   DIV_M2    = RW'(ADC_SQ);

	tclc_pkg::state_t state_q, state_d;
	tclc_pkg::op_t    op_q, op_d, op_nx;

	logic [tclc_pkg::MODE_BITS-1:0] mode_q;
	logic [TW-1:0]                  target_q;

	logic          lamp_q;
	logic [DW-1:0] warm_q, cold_q, semi_int_q, auto_int_q;

	logic [AW-1:0] cct_q, bright_q, light_q;
	logic          motion_q;

	logic [MW-1:0] mc_q;
	logic [AW-1:0] ml_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;

	logic [RW-1:0] rem_q;
	logic [XW-1:0] x_q;
	logic [QW-1:0] quo_q;
	logic          div_lux_q, div_sq_q;

	logic [OBW-1:0] out_data_q;
	logic           out_valid_q;

	logic s_acc, out_free, wb_last, mul_end, div_end;

	// ---------------------------------------------------------------- next state
	always_comb begin
		s_acc    = s_tvalid && (state_q == tclc_pkg::ST_IDLE);
		out_free = !out_valid_q || m_tready;
		mul_end  = (cnt_q == CW'(AW - 1));
		div_end  = div_lux_q ? (cnt_q == CW'(LB - 1)) : (cnt_q == CW'(DW - 1));
		state_d  = state_q;
		op_d     = op_q;
		op_nx    = op_q;
		wb_last  = 1'b0;
		unique case (op_q)
			tclc_pkg::OP_LUX: begin
				if (mode_q == tclc_pkg::MODE_SEMI) op_nx = tclc_pkg::OP_SEMI_COLD;
				else wb_last = 1'b1;
			end
			tclc_pkg::OP_SEMI_COLD: op_nx = tclc_pkg::OP_SEMI_WARM;
			tclc_pkg::OP_MAN_WARM:  op_nx = tclc_pkg::OP_MAN_COLD;
			default:                wb_last = 1'b1;
		endcase
		unique case (state_q)
			tclc_pkg::ST_IDLE: begin
				op_d = tclc_pkg::OP_LUX;
				if (s_acc) begin
					unique case (mode_q) inside
						tclc_pkg::MODE_MANUAL: begin
							op_d    = tclc_pkg::OP_MAN_WARM;
							state_d = lamp_q ? tclc_pkg::ST_LOAD : tclc_pkg::ST_DONE;
						end
						tclc_pkg::MODE_SEMI, tclc_pkg::MODE_AUTO: state_d = tclc_pkg::ST_LOAD;
						default: state_d = tclc_pkg::ST_DONE;
					endcase
				end
			end
			tclc_pkg::ST_LOAD: state_d = tclc_pkg::ST_MUL;
			tclc_pkg::ST_MUL:  if (mul_end) state_d = tclc_pkg::ST_PREP;
			tclc_pkg::ST_PREP: state_d = tclc_pkg::ST_DIV;
			tclc_pkg::ST_DIV:  if (div_end) state_d = tclc_pkg::ST_WB;
			tclc_pkg::ST_WB: begin
				state_d = wb_last ? tclc_pkg::ST_DONE : tclc_pkg::ST_LOAD;
				op_d    = op_nx;
			end
			tclc_pkg::ST_DONE: if (out_free) state_d = tclc_pkg::ST_IDLE;
			default:           state_d = tclc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tclc_pkg::ST_IDLE;
			op_q    <= tclc_pkg::OP_LUX;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tclc_pkg::MODE_MANUAL;
			target_q <= tclc_pkg::TARGET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tclc_pkg::REG_MODE:   mode_q   <= cfg_wdata[tclc_pkg::MODE_BITS-1:0];
				tclc_pkg::REG_TARGET: target_q <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- serial datapath
	logic [XW-1:0] x_full;
	logic [RW-1:0] div_val, trial, trial_sub;
	logic          trial_ge;

	always_comb begin
		if (op_q == tclc_pkg::OP_MAN_WARM || op_q == tclc_pkg::OP_MAN_COLD)
			x_full = {acc_q, {DW{1'b0}}} - XW'(acc_q);   // times full drive
		else
			x_full = XW'(acc_q);
		div_val   = div_sq_q ? DIV_M2 : DIV_M;
		trial     = {rem_q[RW-2:0], x_q[XW-1]};
		trial_ge  = (trial >= div_val);
		trial_sub = trial - div_val;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tclc_pkg::ST_IDLE: begin
				if (s_acc) begin
					cct_q    <= s_tdata[AW-1:0];
					bright_q <= s_tdata[2*AW-1:AW];
					light_q  <= s_tdata[3*AW-1:2*AW];
					motion_q <= s_tdata[3*AW];
				end
			end
			tclc_pkg::ST_LOAD: begin
				acc_q <= '0;
				cnt_q <= '0;
				unique case (op_q)
					tclc_pkg::OP_LUX: begin
						mc_q <= MW'(tclc_pkg::LUX_FULL);
						ml_q <= ADC_MAX - light_q;
					end
					tclc_pkg::OP_MAN_WARM: begin
						mc_q <= MW'(bright_q);
						ml_q <= ADC_MAX - cct_q;
					end
					tclc_pkg::OP_MAN_COLD: begin
						mc_q <= MW'(bright_q);
						ml_q <= cct_q;
					end
					tclc_pkg::OP_SEMI_COLD: begin
						mc_q <= MW'(semi_int_q);
						ml_q <= cct_q;
					end
					default: begin
						mc_q <= MW'(semi_int_q);
						ml_q <= ADC_MAX - cct_q;
					end
				endcase
			end
			tclc_pkg::ST_MUL: begin
				// MSB-first shift-add
				acc_q <= {acc_q[PW-2:0], 1'b0} + (ml_q[AW-1] ? PW'(mc_q) : PW'(0));
				ml_q  <= {ml_q[AW-2:0], 1'b0};
				cnt_q <= cnt_q + CW'(1);
			end
			tclc_pkg::ST_PREP: begin
				// top bits of the dividend are already below the divisor
				cnt_q    <= '0;
				quo_q    <= '0;
				div_lux_q <= (op_q == tclc_pkg::OP_LUX);
				div_sq_q  <= (op_q == tclc_pkg::OP_MAN_WARM || op_q == tclc_pkg::OP_MAN_COLD);
				if (op_q == tclc_pkg::OP_LUX) begin
					rem_q <= RW'(x_full >> LB);
					x_q   <= x_full << (XW - LB);
				end else begin
					rem_q <= RW'(x_full >> DW);
					x_q   <= x_full << (XW - DW);
				end
			end
			tclc_pkg::ST_DIV: begin
				rem_q <= trial_ge ? trial_sub : trial;
				quo_q <= {quo_q[QW-2:0], trial_ge};
				x_q   <= {x_q[XW-2:0], 1'b0};
				cnt_q <= cnt_q + CW'(1);
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- integrator update
	logic [LB-1:0] lux_quo;
	logic          lux_corr;
	logic [DW-1:0] int_old, int_new;
	logic signed [SW-1:0] int_sum;

	always_comb begin
		lux_quo  = quo_q[LB-1:0];
		// truncation toward zero: round the lux up while the difference stays non-negative
		lux_corr = (rem_q != '0) && (TW'(lux_quo) < target_q);
		int_old  = (mode_q == tclc_pkg::MODE_SEMI) ? semi_int_q : auto_int_q;
		int_sum  = $signed(SW'(int_old)) + $signed(SW'(target_q))
		         - $signed(SW'(lux_quo)) - $signed(SW'(lux_corr));
		if (int_sum[SW-1])
			int_new = '0;
		else if (int_sum > $signed(SW'(DRIVE_MAX)))
			int_new = DRIVE_MAX;
		else
			int_new = int_sum[DW-1:0];
	end

	// lamp goes dark once both levels reached zero, motion switches it back on
	function automatic logic motion_in_d(input logic mot, input logic lamp,
	                                     input logic [DW-1:0] warm, input logic [DW-1:0] cold);
		return mot || (lamp && !(warm == '0 && cold == '0));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q     <= 1'b1;
			warm_q     <= '0;
			cold_q     <= '0;
			semi_int_q <= DW'(tclc_pkg::INTEG_RESET);
			auto_int_q <= DW'(tclc_pkg::INTEG_RESET);
		end else if (state_q == tclc_pkg::ST_WB) begin
			unique case (op_q) inside
				tclc_pkg::OP_LUX: begin
					if (mode_q == tclc_pkg::MODE_SEMI) begin
						semi_int_q <= int_new;
					end else begin
						// levels still hold the previous word here
						lamp_q     <= motion_in_d(motion_q, lamp_q, warm_q, cold_q);
						auto_int_q <= int_new;
						warm_q     <= int_new >> 1;
						cold_q     <= int_new >> 1;
					end
				end
				tclc_pkg::OP_MAN_WARM, tclc_pkg::OP_SEMI_WARM: warm_q <= quo_q[DW-1:0];
				default: cold_q <= quo_q[DW-1:0];
			endcase
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tclc_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tclc_pkg::ST_DONE && out_free)
			out_data_q <= OBW'({lamp_q, cold_q, warm_q});
	end

	assign s_tready = (state_q == tclc_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: design/tclc_checker.sv
// Port-level checker for the lamp controller, bound to the top level.
module tclc_checker #(
	parameter int DRIVE_BITS = 13
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((2*DRIVE_BITS+1+7)/8)*8-1:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// words taken in but not yet handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input ready again right after an accept");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("output word with no input word behind it");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two words outstanding");

endmodule

bind two_channel_lamp_lux_controller tclc_checker #(.DRIVE_BITS(DRIVE_BITS)) u_tclc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the two-channel lamp lux controller.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADC_W = 12;
	localparam int DRV_W = 13;
	localparam int S_W = ((3*ADC_W+1+7)/8)*8;
	localparam int M_W = ((2*DRV_W+1+7)/8)*8;
	localparam longint ADC_FULL = (longint'(1) << ADC_W) - 1;
	localparam longint DRIVE_FULL = (longint'(1) << DRV_W) - 1;
	localparam logic [tclc_pkg::MODE_BITS-1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 1930;
	localparam int CALM_TAIL = 150;
	localparam int HOLD_OFF = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE = 100;
	localparam int ROWS = 23;

	typedef struct packed {
		logic [ADC_W-1:0] cct;
		logic [ADC_W-1:0] bright;
		logic [ADC_W-1:0] light;
		logic             motion;
	} lamp_sample_t;

	typedef struct {
		logic [DRV_W-1:0] warm;
		logic [DRV_W-1:0] cold;
		logic             lamp_on;
	} lamp_drive_t;

	typedef struct {
		int mode;
		int target;
		int cct;
		int bright;
		int light;
		int motion;
		int fixed;
		int warm;
		int cold;
		int lamp;
	} opening_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_we;
	logic [tclc_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
	logic [tclc_pkg::CFG_DATA_BITS-1:0] cfg_wdata;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [S_W-1:0]                     s_tdata;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [M_W-1:0]                     m_tdata;

	// predictor state and register copies
	logic [tclc_pkg::MODE_BITS-1:0]   mode_q;
	logic [tclc_pkg::TARGET_BITS-1:0] target_q;
	bit                               lamp_q;
	longint                           warm_q;
	longint                           cold_q;
	longint                           semi_acc;
	longint                           auto_acc;

	lamp_drive_t pending_drive[$];
	int          errors = 0;
	int          stall_count = 0;
	int          snk_chance = 0;
	bit          hold_off_req = 1'b0;

	// mode, target, cct, bright, light, motion, fixed, warm, cold, lamp
	opening_row_t opening_rows [ROWS] = '{
		'{tclc_pkg::MODE_MANUAL, 100,    0, 4095,    0, 0, 1, 8191,    0, 1},
		'{tclc_pkg::MODE_MANUAL, 100, 4095, 4095, 4095, 1, 1,    0, 8191, 1},
		'{tclc_pkg::MODE_MANUAL, 100, 4095,    0, 2048, 0, 1,    0,    0, 1},
		'{tclc_pkg::MODE_MANUAL, 100, 2048, 3000, 1000, 1, 0,    0,    0, 0},
		'{tclc_pkg::MODE_MANUAL, 100,    1,    1, 4095, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_MANUAL, 100, 1234,    0,    0, 0, 1,    0,    0, 1},
		// both held levels zero: lamp drops
		'{tclc_pkg::MODE_AUTO,   100, 2222, 3333, 4095, 0, 1, 1074, 1074, 0},
		'{tclc_pkg::MODE_AUTO,   100, 4095, 4095, 2000, 0, 0,    0,    0, 0},
		// manual with lamp off holds the levels
		'{tclc_pkg::MODE_MANUAL, 100,  100, 4000,  777, 1, 0,    0,    0, 0},
		'{MODE_SPARE,            100, 4095, 4095, 4095, 1, 0,    0,    0, 0},
		'{tclc_pkg::MODE_AUTO,   100,    0,    0,    0, 1, 0,    0,    0, 0},
		// small negative difference truncates to zero
		'{tclc_pkg::MODE_SEMI,     0, 2048, 1111, 4094, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_SEMI,     0,    0, 2222,    0, 1, 0,    0,    0, 0},
		// integrator runs into its upper clamp
		'{tclc_pkg::MODE_SEMI,  1023, 4095,    0, 4095, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_SEMI,  1023,    0,    0, 4095, 1, 0,    0,    0, 0},
		'{tclc_pkg::MODE_SEMI,  1023, 2048,    0, 4095, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_SEMI,  1023,    1,    0, 4095, 1, 0,    0,    0, 0},
		'{tclc_pkg::MODE_SEMI,  1023, 4094,    0, 4095, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_SEMI,  1023, 3000,    0, 4095, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_SEMI,  1023, 4095,    0, 4095, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_AUTO,  1023, 1000, 1000, 4095, 0, 0,    0,    0, 0},
		'{tclc_pkg::MODE_AUTO,     0, 3000, 3000,    0, 1, 0,    0,    0, 0},
		'{tclc_pkg::MODE_MANUAL, 512, 3071, 4095, 2047, 0, 0,    0,    0, 0}
	};

	two_channel_lamp_lux_controller #(
		.ADC_BITS  (ADC_W),
		.DRIVE_BITS(DRV_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// integrator step toward the set point; signed division truncates toward zero
	function automatic longint lux_steer(input longint acc, input longint raw);
		longint diff;
		diff = (longint'(target_q) * ADC_FULL
		       - longint'(tclc_pkg::LUX_FULL) * (ADC_FULL - raw)) / ADC_FULL;
		acc = acc + diff;
		if (acc > DRIVE_FULL)
			acc = DRIVE_FULL;
		if (acc < 0)
			acc = 0;
		return acc;
	endfunction

	function automatic lamp_drive_t next_drive(input lamp_sample_t smp);
		longint      c;
		longint      b;
		longint      raw;
		lamp_drive_t r;
		c = smp.cct;
		b = smp.bright;
		raw = smp.light;
		case (mode_q)
			tclc_pkg::MODE_MANUAL: begin
				if (lamp_q) begin
					warm_q = b * (ADC_FULL - c) * DRIVE_FULL / (ADC_FULL * ADC_FULL);
					cold_q = b * c * DRIVE_FULL / (ADC_FULL * ADC_FULL);
				end
			end
			tclc_pkg::MODE_SEMI: begin
				semi_acc = lux_steer(semi_acc, raw);
				cold_q = semi_acc * c / ADC_FULL;
				warm_q = semi_acc * (ADC_FULL - c) / ADC_FULL;
			end
			tclc_pkg::MODE_AUTO: begin
				if (warm_q == 0 && cold_q == 0)
					lamp_q = 1'b0;
				if (smp.motion)
					lamp_q = 1'b1;
				auto_acc = lux_steer(auto_acc, raw);
				warm_q = auto_acc >>> 1;
				cold_q = auto_acc >>> 1;
			end
			default: ;
		endcase
		r.warm = warm_q[DRV_W-1:0];
		r.cold = cold_q[DRV_W-1:0];
		r.lamp_on = lamp_q;
		return r;
	endfunction

	function automatic lamp_sample_t random_sample();
		lamp_sample_t smp;
		smp.cct = ADC_W'($urandom());
		smp.bright = ADC_W'($urandom());
		smp.light = ADC_W'($urandom());
		case ($urandom_range(0, 7))
			0: smp.cct = '0;
			1: smp.cct = '1;
			2: smp.bright = '0;
			3: smp.bright = '1;
			4: smp.light = '0;
			5: smp.light = '1;
			default: ;
		endcase
		smp.motion = ($urandom_range(0, 2) == 0);
		return smp;
	endfunction

	task automatic write_reg(input logic [tclc_pkg::CFG_ADDR_BITS-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[tclc_pkg::CFG_DATA_BITS-1:0];
		@(posedge clk);
		if (idx == tclc_pkg::REG_MODE)
			mode_q = val[tclc_pkg::MODE_BITS-1:0];
		else
			target_q = val[tclc_pkg::TARGET_BITS-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic offer_word(input lamp_sample_t smp, input bit fixed, input lamp_drive_t want);
		lamp_drive_t got;
		s_tdata <= {{(S_W-3*ADC_W-1){1'b0}}, smp.motion, smp.light, smp.bright, smp.cct};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		got = next_drive(smp);
		pending_drive.push_back(fixed ? want : got);
	endtask

	task automatic source_pause(input int chance);
		if (chance > 0 && $urandom_range(0, 99) < chance) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
	endtask

	// sender stops until the block has handed back every word
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// receiver
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF)
					@(posedge clk);
				m_tready <= 1'b1;
			end else if (snk_chance > 0 && $urandom_range(0, 99) < snk_chance) begin
				gap = $urandom_range(1, 18);
				m_tready <= 1'b0;
				repeat (gap)
					@(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		lamp_drive_t want;
		lamp_drive_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen.warm = m_tdata[DRV_W-1:0];
			seen.cold = m_tdata[2*DRV_W-1:DRV_W];
			seen.lamp_on = m_tdata[2*DRV_W];
			if (pending_drive.size() == 0) begin
				$display("%0t: unexpected word: warm %0d cold %0d lamp %0d", $time,
					seen.warm, seen.cold, seen.lamp_on);
				errors++;
			end else begin
				want = pending_drive.pop_front();
				if (seen.warm !== want.warm) begin
					$display("%0t: warm_drive expected %0d actual %0d", $time, want.warm, seen.warm);
					errors++;
				end
				if (seen.cold !== want.cold) begin
					$display("%0t: cold_drive expected %0d actual %0d", $time, want.cold, seen.cold);
					errors++;
				end
				if (seen.lamp_on !== want.lamp_on) begin
					$display("%0t: lamp_on expected %0d actual %0d", $time, want.lamp_on,
						seen.lamp_on);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("two_channel_lamp_lux_controller verification failed");
			$finish;
		end
	end

	initial begin
		lamp_sample_t                   smp;
		lamp_drive_t                    want;
		lamp_drive_t                    blank;
		logic [tclc_pkg::MODE_BITS-1:0] next_mode;
		int                             next_target;
		int                             sent;
		int                             len;
		int                             phase;
		int                             src_chance;
		bit                             calm;
		blank = '{0, 0, 0};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		mode_q = tclc_pkg::MODE_MANUAL;
		target_q = tclc_pkg::TARGET_RESET;
		lamp_q = 1'b1;
		warm_q = 0;
		cold_q = 0;
		semi_acc = tclc_pkg::INTEG_RESET;
		auto_acc = tclc_pkg::INTEG_RESET;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		snk_chance = 15;
		settle_block();

		foreach (opening_rows[i]) begin
			if (opening_rows[i].mode != mode_q || opening_rows[i].target != target_q) begin
				settle_block();
				if (opening_rows[i].mode != mode_q)
					write_reg(tclc_pkg::REG_MODE, opening_rows[i].mode);
				if (opening_rows[i].target != target_q)
					write_reg(tclc_pkg::REG_TARGET, opening_rows[i].target);
			end
			smp.cct = opening_rows[i].cct[ADC_W-1:0];
			smp.bright = opening_rows[i].bright[ADC_W-1:0];
			smp.light = opening_rows[i].light[ADC_W-1:0];
			smp.motion = opening_rows[i].motion[0];
			want.warm = opening_rows[i].warm[DRV_W-1:0];
			want.cold = opening_rows[i].cold[DRV_W-1:0];
			want.lamp_on = opening_rows[i].lamp[0];
			offer_word(smp, opening_rows[i].fixed != 0, want);
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			len = $urandom_range(20, 120);
			if (len > RANDOM_WORDS - sent)
				len = RANDOM_WORDS - sent;
			calm = (RANDOM_WORDS - sent <= CALM_TAIL);
			settle_block();
			case ($urandom_range(0, 15)) inside
				[0:4]: next_mode = tclc_pkg::MODE_MANUAL;
				[5:9]: next_mode = tclc_pkg::MODE_SEMI;
				15: next_mode = MODE_SPARE;
				default: next_mode = tclc_pkg::MODE_AUTO;
			endcase
			case ($urandom_range(0, 3))
				0: next_target = 0;
				1: next_target = (1 << tclc_pkg::TARGET_BITS) - 1;
				default: next_target = $urandom_range(0, (1 << tclc_pkg::TARGET_BITS) - 1);
			endcase
			write_reg(tclc_pkg::REG_MODE, int'(next_mode));
			write_reg(tclc_pkg::REG_TARGET, next_target);
			src_chance = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			snk_chance = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			if (calm) begin
				src_chance = 0;
				snk_chance = 0;
			end
			// long receiver hold-off with the sender pressing on
			if (phase == 1) begin
				hold_off_req = 1'b1;
				src_chance = 0;
			end
			repeat (len) begin
				offer_word(random_sample(), 1'b0, blank);
				source_pause(src_chance);
				sent++;
			end
			phase++;
		end

		settle_block();
		repeat (SETTLE)
			@(posedge clk);
		if (errors == 0 && pending_drive.size() == 0)
			$display("two_channel_lamp_lux_controller verification clean");
		else
			$display("two_channel_lamp_lux_controller verification failed");
		$finish;
	end

endmodule
